/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the periodic timer bank RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PTB_ASSERT_ALWAYS(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// Implication property (use |-> or |=> inside prop).
`define PTB_ASSERT_IMPL(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

`endif

/* hw/rtl/ptb_pkg.sv */
// Package for the periodic timer bank: operation codes, field widths and
// the structs passed between the timer cells, the result stage and the top.
// No dependencies.
package ptb_pkg;

  localparam int TIMER_COUNT_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int DELAY_W = 16;
  localparam int REPS_W  = 16;
  localparam int ADV_W   = 8;
  localparam int TIME_W  = 32;

  localparam logic [REPS_W-1:0] REPS_ENDLESS = '1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  // Command broadcast to all cells for start, stop and delete.
  typedef struct packed {
    logic               wr;
    op_t                op;
    logic [DELAY_W-1:0] delay;
    logic [REPS_W-1:0]  reps;
  } cell_cmd_t;

  // What a cell reports while it holds the scan token.
  typedef struct packed {
    logic              fire;
    logic [REPS_W-1:0] reps_after;
  } cell_status_t;

  // Firing candidate handed to the result stage.
  typedef struct packed {
    logic              fire;
    logic [IDX_W-1:0]  idx;
    logic [REPS_W-1:0] reps;
  } fire_cand_t;

endpackage

/* hw/rtl/ptb_cell.sv */
// One timer slot of the periodic timer bank, a link in the scan chain.
// Depends on ptb_pkg.
module ptb_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  ptb_pkg::cell_cmd_t              cmd,
  input  logic                            sel,
  input  logic [ptb_pkg::TIME_W-1:0]      now,
  input  logic                            step,
  input  logic                            tok_in,
  output logic                            tok,
  output ptb_pkg::cell_status_t           status
);

  logic                          running;
  logic [ptb_pkg::DELAY_W-1:0]   period;
  logic [ptb_pkg::REPS_W-1:0]    reps;
  logic [ptb_pkg::TIME_W-1:0]    stamp;
  logic [ptb_pkg::TIME_W-1:0]    elapsed;
  logic                          due;

  // Elapsed time wraps modulo 2^32; the period is only 16 bits wide.
  assign elapsed = now - stamp;
  assign due = (elapsed[ptb_pkg::TIME_W-1:ptb_pkg::DELAY_W] != '0) ||
               (elapsed[ptb_pkg::DELAY_W-1:0] >= period);

  assign status.fire       = tok && running && due;
  assign status.reps_after = (reps == ptb_pkg::REPS_ENDLESS) ? reps
                                                             : reps - ptb_pkg::REPS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      running <= 1'b0;
      period  <= '0;
      reps    <= '0;
      stamp   <= '0;
    end else begin
      if (step) begin
        tok <= tok_in;
      end
      if (cmd.wr && sel) begin
        unique case (cmd.op)
          ptb_pkg::OP_START: begin
            running <= 1'b1;
            period  <= cmd.delay;
            reps    <= cmd.reps;
            stamp   <= now;
          end
          ptb_pkg::OP_STOP: begin
            running <= 1'b0;
            reps    <= '0;
          end
          ptb_pkg::OP_DELETE: begin
            running <= 1'b0;
            period  <= '0;
            reps    <= '0;
            stamp   <= '0;
          end
          ptb_pkg::OP_TICK: begin
          end
          default: begin
          end
        endcase
      end else if (step && status.fire) begin
        // Lateness compensation: now - (elapsed - period) is stamp + period.
        stamp   <= stamp + ptb_pkg::TIME_W'(period);
        reps    <= status.reps_after;
        running <= (status.reps_after != '0);
      end
    end
  end

endmodule

/* hw/rtl/ptb_collect.sv */
// Result stage of the periodic timer bank: holds one firing back so the
// last one of a scan can be marked, then drives the output register.
// Depends on ptb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptb_collect (
  input  logic                            clk,
  input  logic                            rst,
  input  ptb_pkg::fire_cand_t             cand,
  input  logic                            flush,
  output logic                            stall,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // fired_index, repeats_left, pad
  output logic                            m_axis_tlast   // last
);

  logic                           pend_valid;
  logic [ptb_pkg::IDX_W-1:0]      pend_idx;
  logic [ptb_pkg::REPS_W-1:0]     pend_reps;
  logic [ptb_pkg::IDX_W-1:0]      out_idx;
  logic [ptb_pkg::REPS_W-1:0]     out_reps;
  logic                           out_free;
  logic                           push_req;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign push_req = pend_valid && (cand.fire || flush);
  assign stall    = push_req && !out_free;

  assign m_axis_tdata = {4'b0000, out_reps, out_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (push_req && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cand.fire && !stall) begin
        pend_valid <= 1'b1;
      end else if (flush && !stall) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_req && out_free) begin
      out_idx      <= pend_idx;
      out_reps     <= pend_reps;
      m_axis_tlast <= flush;
    end
    if (cand.fire && !stall) begin
      pend_idx  <= cand.idx;
      pend_reps <= cand.reps;
    end
  end

  `PTB_ASSERT_ALWAYS(a_stall_has_data, clk, rst,
                     !stall || (pend_valid && m_axis_tvalid), "stall without held firing")
  `PTB_ASSERT_IMPL(a_flush_marks_last, clk, rst,
                   (flush && pend_valid && !stall) |=> (m_axis_tvalid && m_axis_tlast),
                   "final firing not marked last")

endmodule

/* hw/rtl/periodic_timer_bank_top.sv */
// Periodic timer bank: TIMER_COUNT timer slots against a wrapping 32-bit ms clock.
// Start, stop and delete requests are applied when accepted. A tick request
// holds off further requests: the scan token walks the cell chain one slot per cycle
// unless output back-pressure stalls it, then a flush step passes on the held firing.
// Reset (rst, synchronous, active high) clears the clock and every slot.
// Depends on ptb_pkg, ptb_cell, ptb_collect and assert_macros.svh.
`include "assert_macros.svh"

module periodic_timer_bank_top #(
  parameter int TIMER_COUNT = ptb_pkg::TIMER_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // timer_index, delay, repeat_count, tick_advance, pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // fired_index, repeats_left, pad
  output logic        m_axis_tlast   // last
);

  // Unpacked request fields.
  logic [ptb_pkg::IDX_W-1:0]   in_idx;
  logic [ptb_pkg::DELAY_W-1:0] in_delay;
  logic [ptb_pkg::REPS_W-1:0]  in_reps;
  logic [ptb_pkg::ADV_W-1:0]   in_adv;
  ptb_pkg::op_t                in_op;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_delay = s_axis_tdata[19:4];
  assign in_reps  = s_axis_tdata[35:20];
  assign in_adv   = s_axis_tdata[43:36];
  assign in_op    = ptb_pkg::op_t'(s_axis_tuser);

  // Control: busy covers the whole tick, from acceptance to the flush.
  logic                        busy;
  logic                        flush;
  logic [ptb_pkg::TIME_W-1:0]  now;
  logic                        in_accept;
  logic                        tick_go;
  logic                        step;
  logic                        stall;
  logic                        flush_done;

  ptb_pkg::cell_cmd_t          cmd;
  logic [TIMER_COUNT-1:0]      sel;
  logic [TIMER_COUNT-1:0]      tok;
  logic [TIMER_COUNT-1:0]      tok_in;
  ptb_pkg::cell_status_t       status [TIMER_COUNT];
  ptb_pkg::fire_cand_t         cand;

  assign s_axis_tready = !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign tick_go       = in_accept && (in_op == ptb_pkg::OP_TICK);

  // The chain moves only when the result stage can take a firing.
  assign step       = tick_go || (busy && !stall);
  assign flush_done = flush && !stall;

  assign cmd.wr    = in_accept && (in_op != ptb_pkg::OP_TICK);
  assign cmd.op    = in_op;
  assign cmd.delay = in_delay;
  assign cmd.reps  = in_reps;

  // Token enters the first cell on a tick and ripples toward the last.
  assign tok_in[0] = tick_go;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign tok_in[i] = tok[i-1];
    end
    // Slot indices beyond the bank never match, so such requests are dropped.
    assign sel[i] = ({4'b0000, in_idx} == 8'(i));

    ptb_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sel    (sel[i]),
      .now    (now),
      .step   (step),
      .tok_in (tok_in[i]),
      .tok    (tok[i]),
      .status (status[i])
    );
  end

  // Only the cell holding the token can report a firing.
  always_comb begin
    cand = '0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      if (tok[i]) begin
        cand.fire = status[i].fire;
        cand.idx  = ptb_pkg::IDX_W'(i);
        cand.reps = status[i].reps_after;
      end
    end
  end

  ptb_collect u_collect (
    .clk           (clk),
    .rst           (rst),
    .cand          (cand),
    .flush         (flush),
    .stall         (stall),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The clock advances when the tick is accepted, so every cell sees the new time.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      flush <= 1'b0;
      now   <= '0;
    end else begin
      if (tick_go) begin
        busy  <= 1'b1;
        flush <= 1'b0;
        now   <= now + ptb_pkg::TIME_W'(in_adv);
      end else if (tok[TIMER_COUNT-1] && step) begin
        flush <= 1'b1;
      end else if (flush_done) begin
        flush <= 1'b0;
        busy  <= 1'b0;
      end
    end
  end

  `PTB_ASSERT_ALWAYS(a_tok_onehot, clk, rst, $onehot0(tok), "more than one scan token")
  `PTB_ASSERT_IMPL(a_flush_no_tok, clk, rst, flush |-> (tok == '0), "flush while scan token present")
  `PTB_ASSERT_IMPL(a_tick_starts_scan, clk, rst, tick_go |=> tok[0], "tick did not start scan")
  `PTB_ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready |-> ((tok == '0) && !flush), "ready during a scan")

endmodule

/* test/periodic_timer_bank_top_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_bank_top: a directed table, then random requests
// in three back-pressure phases, every firing checked against a listed row result or a behavioral timer bank.
// Depends on ptb_pkg and the periodic_timer_bank_top RTL.
module periodic_timer_bank_top_test;
  import ptb_pkg::*;

  localparam int SLOTS         = 16;
  localparam int SCAN_CYCLES   = SLOTS + 2;
  localparam int DRAIN_CYCLES  = 3 * SCAN_CYCLES;
  localparam int RANDOM_PHASE  = 113;
  localparam int PREDICT       = -1;  // row result comes from the timer bank model
  localparam logic [15:0] ENDLESS = 16'hFFFF;

  typedef struct packed {
    op_t         op;
    logic [3:0]  slot;
    logic [15:0] delay;
    logic [15:0] reps;
    logic [7:0]  adv;
  } timer_req_t;

  typedef struct packed {
    logic [3:0]  fired_index;
    logic [15:0] repeats_left;
    logic        last;
  } firing_t;

  localparam firing_t NO_FIRING = '0;

  // A row either lists what it must produce (zero or one firing) or defers to the model.
  typedef struct {
    timer_req_t req;
    int         n_known;
    firing_t    known;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 24;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // Tick straight out of reset: nothing is running.
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    // Zero repeat count: first firing turns it into endless.
    '{'{OP_START,  4'd0,  16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd0},   1,       '{4'd0, ENDLESS, 1'b1}},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd255}, 1,       '{4'd0, ENDLESS, 1'b1}},
    '{'{OP_STOP,   4'd0,  16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd255}, 0,       NO_FIRING},
    // Longest period, endless; the advance field of a start is ignored.
    '{'{OP_START,  4'd15, 16'hFFFF,  ENDLESS,   8'd255}, 0,       NO_FIRING},
    // Most negative count wraps to the largest positive one on the first firing.
    '{'{OP_START,  4'd7,  16'd3,     16'h8000,  8'd0},   0,       NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd2},   PREDICT, NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd1},   1,       '{4'd7, 16'h7FFF, 1'b1}},
    '{'{OP_START,  4'd3,  16'd1,     16'd1,     8'd0},   0,       NO_FIRING},
    // Two firings on one tick; slot 3 runs out, slot 7 is late and compensated.
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd255}, PREDICT, NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd0},   PREDICT, NO_FIRING},
    '{'{OP_DELETE, 4'd7,  16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    '{'{OP_START,  4'd5,  16'd100,   16'h7FFF,  8'd0},   0,       NO_FIRING},
    // Tick with every unused field at all ones.
    '{'{OP_TICK,   4'd15, 16'hFFFF,  ENDLESS,   8'd255}, PREDICT, NO_FIRING},
    '{'{OP_STOP,   4'd5,  16'hFFFF,  ENDLESS,   8'd255}, 0,       NO_FIRING},
    '{'{OP_DELETE, 4'd15, 16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    '{'{OP_DELETE, 4'd3,  16'd0,     16'd0,     8'd0},   0,       NO_FIRING},
    // Zero period fires on every tick, even one that does not advance the clock.
    '{'{OP_START,  4'd10, 16'd0,     16'd2,     8'd0},   0,       NO_FIRING},
    '{'{OP_START,  4'd11, 16'd0,     ENDLESS,   8'd0},   0,       NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd0},   PREDICT, NO_FIRING},
    '{'{OP_TICK,   4'd0,  16'd0,     16'd0,     8'd255}, PREDICT, NO_FIRING},
    '{'{OP_STOP,   4'd11, 16'd0,     16'd0,     8'd0},   0,       NO_FIRING}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  periodic_timer_bank_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Behavioral copy of the timer bank.
  logic [31:0] bank_time = '0;
  logic        slot_running [SLOTS] = '{default: 1'b0};
  logic [15:0] slot_period  [SLOTS] = '{default: '0};
  logic [15:0] slot_repeats [SLOTS] = '{default: '0};
  logic [31:0] slot_stamp   [SLOTS] = '{default: '0};

  firing_t expected_firings [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int ticks_sent = 0;
  int firings_checked = 0;
  int busiest_tick = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Applies one accepted request to the model and returns the firings it causes.
  task automatic predict_firings(input timer_req_t req, output firing_t fires [$]);
    logic [31:0] elapsed;
    firing_t     f;
    fires = {};
    case (req.op)
      OP_START: begin
        slot_running[req.slot] = 1'b1;
        slot_period[req.slot]  = req.delay;
        slot_repeats[req.slot] = req.reps;
        slot_stamp[req.slot]   = bank_time;
      end
      OP_STOP: begin
        slot_running[req.slot] = 1'b0;
        slot_repeats[req.slot] = '0;
      end
      OP_DELETE: begin
        slot_running[req.slot] = 1'b0;
        slot_period[req.slot]  = '0;
        slot_repeats[req.slot] = '0;
        slot_stamp[req.slot]   = '0;
      end
      default: begin
        bank_time = bank_time + 32'(req.adv);
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_running[i]) begin
            elapsed = bank_time - slot_stamp[i];
            if (elapsed >= 32'(slot_period[i])) begin
              // Lateness carries over into the next period.
              slot_stamp[i] = bank_time - (elapsed - 32'(slot_period[i]));
              if (slot_repeats[i] != ENDLESS) begin
                slot_repeats[i] = slot_repeats[i] - 16'd1;
                if (slot_repeats[i] == '0) slot_running[i] = 1'b0;
              end
              f.fired_index  = 4'(i);
              f.repeats_left = slot_repeats[i];
              f.last         = 1'b0;
              fires.push_back(f);
            end
          end
        end
        if (fires.size() > 0) fires[fires.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // Drives one request from a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(input timer_req_t req, input int n_known, input firing_t known);
    firing_t fires [$];
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, req.adv, req.reps, req.delay, req.slot};
    s_axis_tuser  <= req.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_firings(req, fires);
    if (n_known == PREDICT) expected_firings = {expected_firings, fires};
    else if (n_known == 1) expected_firings.push_back(known);
    requests_sent++;
    if (req.op == OP_TICK) begin
      ticks_sent++;
      if (fires.size() > busiest_tick) busiest_tick = fires.size();
    end
    @(negedge clk);
  endtask

  task automatic random_request(output timer_req_t req);
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) req.op = OP_TICK;
    else if (pick < 75) req.op = OP_START;
    else if (pick < 85) req.op = OP_STOP;
    else req.op = OP_DELETE;
    req.slot = 4'($urandom_range(SLOTS - 1));
    case ($urandom_range(9))
      0: req.delay = '0;
      1: req.delay = 16'hFFFF;
      2, 3: req.delay = 16'($urandom);
      default: req.delay = 16'($urandom_range(600));
    endcase
    case ($urandom_range(9))
      0, 1: req.reps = ENDLESS;
      2: req.reps = '0;
      3: req.reps = 16'h8000;
      4: req.reps = 16'($urandom);
      default: req.reps = 16'($urandom_range(1, 6));
    endcase
    req.adv = 8'($urandom_range(255));
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Checks each accepted firing against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_firings.size() == 0) begin
        $error("unexpected firing: fired_index %0d, repeats_left %0d, last %0b",
               m_axis_tdata[3:0], $signed(m_axis_tdata[19:4]), m_axis_tlast);
        mismatch_count++;
      end else begin
        firing_t want;
        want = expected_firings.pop_front();
        firings_checked++;
        if (m_axis_tdata[3:0] !== want.fired_index) begin
          $error("fired_index: expected %0d, got %0d", want.fired_index, m_axis_tdata[3:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[19:4] !== want.repeats_left) begin
          $error("repeats_left: expected %0d, got %0d",
                 $signed(want.repeats_left), $signed(m_axis_tdata[19:4]));
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    timer_req_t req;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    m_axis_tready = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_table[r])
      send_request(directed_table[r].req, directed_table[r].n_known, directed_table[r].known);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Load every slot with a short period so that the next ticks fire many at once.
      for (int s = 0; s < SLOTS; s++) begin
        random_request(req);
        req.op    = OP_START;
        req.slot  = 4'(s);
        req.delay = 16'($urandom_range(40));
        send_request(req, PREDICT, NO_FIRING);
      end
      repeat (RANDOM_PHASE) begin
        random_request(req);
        send_request(req, PREDICT, NO_FIRING);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_firings.size() != 0) @(posedge clk);
    // A tick that fires nothing may still be scanning; let any stray firing show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests including %0d ticks; checked %0d firings.",
             requests_sent, ticks_sent, firings_checked);
    $display("Most firings caused by one tick: %0d of %0d slots.", busiest_tick, SLOTS);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
